// ===== sv/dgp_pkg.sv =====
// Shared types and constants of the discovery datagram parser.
// Used by every module of the parser; no dependencies.
package dgp_pkg;

   localparam int POS_W       = 16;
   localparam int HDR_BYTES   = 6;
   localparam int MAGIC_BYTES = 4;
   localparam int VER_POS     = 4;
   localparam int TYPE_POS    = 5;
   localparam int PORT_BYTES  = 2;
   localparam int LEN_BYTES   = 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_CODE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_CODE       = 2'd2;

   // Magic "ALTX"
   localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h41, 8'h4C, 8'h54, 8'h58};

   typedef enum logic [1:0] {
      MSG_UNKNOWN = 2'd0,
      MSG_QUERY   = 2'd1,
      MSG_REPLY   = 2'd2
   } msg_type;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_ID       = 3'd1,
      KIND_PORT     = 3'd2,
      KIND_NAME_LEN = 3'd3,
      KIND_NAME     = 3'd4,
      KIND_TRAILING = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [7:0] query_code;
      logic [7:0] reply_code;
   } cfg_type;

   // Classified item handed from the front to the back
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic        last;
      logic        header_ok;
      msg_type     msg;
      logic        got_hdr;
      logic        got_id;
      logic        got_len;
      logic        got_name;
      logic [15:0] port;
      logic [7:0]  name_count;
   } item_type;

endpackage

// ===== sv/dgp_chan_if.sv =====
// Valid/ready channel interfaces of the discovery datagram parser.
// dgp_req_if carries datagram bytes in, dgp_rsp_if carries tagged bytes out.
interface dgp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_datagram;

   modport source (output valid, output in_byte, output end_of_datagram, input ready);
   modport sink (input valid, input in_byte, input end_of_datagram, output ready);
endinterface

interface dgp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [2:0]  field_kind;
   logic        done_res;
   logic        accepted;
   logic        msg_kind;
   logic [15:0] peer_port;
   logic [7:0]  name_length;

   modport source (output valid, output out_byte, output field_kind, output done_res,
                   output accepted, output msg_kind, output peer_port,
                   output name_length, input ready);
   modport sink (input valid, input out_byte, input field_kind, input done_res,
                 input accepted, input msg_kind, input peer_port, input name_length,
                 output ready);
endinterface

// ===== sv/dgp_front.sv =====
// Front end of the parser: accepts bytes, tracks the frame position and fields,
// and tags each byte. Depends on dgp_pkg and dgp_req_if.
module dgp_front #(
   parameter int ID_FIELD_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  dgp_pkg::cfg_type  cfg,
   dgp_req_if.sink           req,
   input  logic              full,
   output logic              push,
   output dgp_pkg::item_type item
);

   localparam int ID_END   = dgp_pkg::HDR_BYTES + ID_FIELD_BYTES;
   localparam int PORT_END = ID_END + dgp_pkg::PORT_BYTES;
   localparam int LEN_END  = PORT_END + dgp_pkg::LEN_BYTES;
   localparam int CNT_W    = dgp_pkg::POS_W + 1;

   logic [dgp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      hdr_ok_ff, hdr_ok_in;
   dgp_pkg::msg_type          msg_ff, msg_in;
   logic [15:0]               port_ff, port_in;
   logic [7:0]                nlen_ff, nlen_in;

   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] name_end_cur;
   logic [CNT_W-1:0] name_end_new;
   logic [7:0]       data;
   dgp_pkg::kind_type kind;

   assign req.ready = !full;
   assign push      = req.valid && !full;

   // Classify the byte and work out the next frame state
   always_comb begin
      hdr_ok_in    = hdr_ok_ff;
      msg_in       = msg_ff;
      port_in      = port_ff;
      nlen_in      = nlen_ff;
      data         = req.in_byte;
      name_end_cur = CNT_W'(LEN_END) + {{(CNT_W-8){1'b0}}, nlen_ff};
      if (pos_ff < dgp_pkg::POS_W'(dgp_pkg::MAGIC_BYTES)) begin
         if (req.in_byte != dgp_pkg::MAGIC[pos_ff[1:0]]) hdr_ok_in = 1'b0;
         kind = dgp_pkg::KIND_HEADER;
      end else if (pos_ff == dgp_pkg::POS_W'(dgp_pkg::VER_POS)) begin
         if (req.in_byte != cfg.expected_version) hdr_ok_in = 1'b0;
         kind = dgp_pkg::KIND_HEADER;
      end else if (pos_ff == dgp_pkg::POS_W'(dgp_pkg::TYPE_POS)) begin
         if (req.in_byte == cfg.query_code) msg_in = dgp_pkg::MSG_QUERY;
         else if (req.in_byte == cfg.reply_code) msg_in = dgp_pkg::MSG_REPLY;
         else msg_in = dgp_pkg::MSG_UNKNOWN;
         kind = dgp_pkg::KIND_HEADER;
      end else if (pos_ff < dgp_pkg::POS_W'(ID_END)) begin
         // last ID byte is blanked
         if (pos_ff == dgp_pkg::POS_W'(ID_END - 1)) data = 8'd0;
         kind = dgp_pkg::KIND_ID;
      end else if (msg_ff != dgp_pkg::MSG_REPLY) begin
         kind = dgp_pkg::KIND_TRAILING;
      end else if (pos_ff < dgp_pkg::POS_W'(PORT_END)) begin
         port_in = {port_ff[7:0], req.in_byte};
         kind    = dgp_pkg::KIND_PORT;
      end else if (pos_ff < dgp_pkg::POS_W'(LEN_END)) begin
         nlen_in = req.in_byte;
         kind    = dgp_pkg::KIND_NAME_LEN;
      end else if ({1'b0, pos_ff} < name_end_cur) begin
         kind = dgp_pkg::KIND_NAME;
      end else begin
         kind = dgp_pkg::KIND_TRAILING;
      end

      count        = {1'b0, pos_ff} + CNT_W'(1);
      name_end_new = CNT_W'(LEN_END) + {{(CNT_W-8){1'b0}}, nlen_in};
      pos_in       = (pos_ff == '1) ? pos_ff : pos_ff + dgp_pkg::POS_W'(1);
   end

   // Hand the tagged byte and the frame status on
   always_comb begin
      item.data       = data;
      item.kind       = kind;
      item.last       = req.end_of_datagram;
      item.header_ok  = hdr_ok_in;
      item.msg        = msg_in;
      item.got_hdr    = count >= CNT_W'(dgp_pkg::HDR_BYTES);
      item.got_id     = count >= CNT_W'(ID_END);
      item.got_len    = count >= CNT_W'(LEN_END);
      item.got_name   = count >= name_end_new;
      item.port       = port_in;
      item.name_count = nlen_in;
   end

   // Advance the frame state; clear it after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b1;
         msg_ff    <= dgp_pkg::MSG_UNKNOWN;
         port_ff   <= '0;
         nlen_ff   <= '0;
      end else if (push) begin
         if (req.end_of_datagram) begin
            pos_ff    <= '0;
            hdr_ok_ff <= 1'b1;
            msg_ff    <= dgp_pkg::MSG_UNKNOWN;
            port_ff   <= '0;
            nlen_ff   <= '0;
         end else begin
            pos_ff    <= pos_in;
            hdr_ok_ff <= hdr_ok_in;
            msg_ff    <= msg_in;
            port_ff   <= port_in;
            nlen_ff   <= nlen_in;
         end
      end
   end

endmodule

// ===== sv/dgp_queue.sv =====
// Two-entry item queue between the front and the back of the parser.
// Depends on dgp_pkg.
module dgp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dgp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output dgp_pkg::item_type pop_item,
   output logic              empty
);

   dgp_pkg::item_type mem_ff [2];
   logic              wr_ff;
   logic              rd_ff;
   logic [1:0]        count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_item = mem_ff[rd_ff];

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   // Move the pointers and the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ===== sv/dgp_back.sv =====
// Back end of the parser: forms the verdict on the final byte and holds the
// result in the output register. Depends on dgp_pkg and dgp_rsp_if.
module dgp_back #(
   parameter int NAME_STORE_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  dgp_pkg::item_type item,
   output logic              pop,
   dgp_rsp_if.source         rsp
);

   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic [2:0]  kind_ff;
   logic        done_ff;
   logic        acc_ff, acc_in;
   logic        reply_ff, reply_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  nlen_ff, nlen_in;
   logic        len_fits;
   logic        query_ok;
   logic        reply_ok;

   assign pop = !empty && (!valid_ff || rsp.ready);

   // Decide the verdict and mask the reply fields
   always_comb begin
      len_fits = {1'b0, item.name_count} <= 9'(NAME_STORE_BYTES - 1);
      query_ok = (item.msg == dgp_pkg::MSG_QUERY) && item.got_id;
      reply_ok = (item.msg == dgp_pkg::MSG_REPLY) && item.got_len && item.got_name
                 && len_fits;
      acc_in   = item.last && item.header_ok && item.got_hdr && (query_ok || reply_ok);
      reply_in = acc_in && (item.msg == dgp_pkg::MSG_REPLY);
      port_in  = reply_in ? item.port : 16'd0;
      nlen_in  = reply_in ? item.name_count : 8'd0;
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff  <= item.data;
         kind_ff  <= item.kind;
         done_ff  <= item.last;
         acc_ff   <= acc_in;
         reply_ff <= reply_in;
         port_ff  <= port_in;
         nlen_ff  <= nlen_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.field_kind  = kind_ff;
   assign rsp.done_res    = done_ff;
   assign rsp.accepted    = acc_ff;
   assign rsp.msg_kind    = reply_ff;
   assign rsp.peer_port   = port_ff;
   assign rsp.name_length = nlen_ff;

endmodule

// ===== sv/discovery_datagram_parser_core.sv =====
// Discovery datagram parser, top level.
// Usage:
//   req_bus carries one datagram byte per item (in_byte) with end_of_datagram
//   set on the final byte. rsp_bus returns one item per byte: the byte echoed
//   (zero at the last ID byte), its field tag, and on the final byte the
//   verdict, message kind, peer port and name length.
//   csr_wr_en/csr_index/csr_wr_data write expected_version (0), query_code (1)
//   and reply_code (2); other indexes are ignored. Write only while idle.
// Timing:
//   One byte per cycle sustained while rsp_bus is ready. An accepted byte is
//   written into the two-entry queue and moves into the back output register
//   once that register is free or being taken, then appears on rsp_bus.
//   The frame state updates only small registers, so the front takes a byte
//   every cycle as long as the queue has room.
// Reset (synchronous, active high) restores the register defaults, clears
//   the frame state and empties the queue and output register.
// When rsp_bus stalls, the output register holds its item and the queue
//   fills; req_bus.ready drops once both queue entries are taken.
// Depends on dgp_pkg, dgp_chan_if, dgp_front, dgp_queue and dgp_back.
module discovery_datagram_parser_core #(
   parameter int ID_FIELD_BYTES   = 32,
   parameter int NAME_STORE_BYTES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   dgp_req_if.sink                            req_bus,
   dgp_rsp_if.source                          rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [dgp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dgp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   dgp_pkg::cfg_type  cfg_ff;
   dgp_pkg::item_type front_item;
   dgp_pkg::item_type back_item;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= 8'd1;
         cfg_ff.query_code       <= 8'd0;
         cfg_ff.reply_code       <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dgp_pkg::CSR_EXPECTED_VERSION: cfg_ff.expected_version <= csr_wr_data;
            dgp_pkg::CSR_QUERY_CODE:       cfg_ff.query_code       <= csr_wr_data;
            dgp_pkg::CSR_REPLY_CODE:       cfg_ff.reply_code       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   dgp_front #(
      .ID_FIELD_BYTES (ID_FIELD_BYTES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_bus),
      .full  (q_full),
      .push  (q_push),
      .item  (front_item)
   );

   dgp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   dgp_back #(
      .NAME_STORE_BYTES (NAME_STORE_BYTES)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .empty (q_empty),
      .item  (back_item),
      .pop   (q_pop),
      .rsp   (rsp_bus)
   );

endmodule
